// ===== hw/rtl/board_power_sequencer_supervisor_defines.svh =====
// assertion macros shared by the supervisor rtl
`ifndef BOARD_POWER_SEQUENCER_SUPERVISOR_DEFINES_SVH
`define BOARD_POWER_SEQUENCER_SUPERVISOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BPSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bpss_pkg.sv =====
// types and constants of the board power sequencer and supervisor
`default_nettype none

package bpss_pkg;

  // configuration port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOARD_VARIANT = 3'd0,
    CFG_FAN_RUN_DUTY  = 3'd1,
    CFG_FAN_FAIL_DUTY = 3'd2,
    CFG_FAN_HOLD      = 3'd3,
    CFG_SWITCH_DELAY  = 3'd4,
    CFG_BLINK_HALF    = 3'd5
  } bpss_cfg_idx_t;

  // board variants
  localparam logic [1:0] VAR_FAN_BOARD   = 2'd0;
  localparam logic [1:0] VAR_TWO_LED     = 2'd1;
  localparam logic [1:0] VAR_RELAY_BOARD = 2'd2;

  // power sequencer phases
  typedef enum logic [1:0] {
    PH_DOWN = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2,
    PH_UP   = 2'd3
  } bpss_phase_t;

  // register reset values
  localparam logic [1:0]  RST_BOARD_VARIANT = VAR_TWO_LED;
  localparam logic [7:0]  RST_FAN_RUN_DUTY  = 8'd10;
  localparam logic [7:0]  RST_FAN_FAIL_DUTY = 8'd255;
  localparam logic [7:0]  RST_FAN_HOLD      = 8'd10;
  localparam logic [15:0] RST_SWITCH_DELAY  = 16'd5000;
  localparam logic [15:0] RST_BLINK_HALF    = 16'd500;

  // number of tachometer level monitors (fan1 high/low, fan2 high/low)
  localparam int unsigned FAN_LINES = 4;

  // control from the top level to the fan monitor
  typedef struct packed {
    logic       tick;
    logic [7:0] hold;
  } bpss_fan_ctl_t;

  // status from the fan monitor
  typedef struct packed {
    logic all_seen_nxt;
  } bpss_fan_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bpss_if.sv =====
// handshake channel interfaces of the supervisor
`default_nettype none

// input word channel
interface bpss_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic mode_12v_pin;
  logic proc_alive;
  logic fan1_high_seen;
  logic fan1_low_seen;
  logic fan2_high_seen;
  logic fan2_low_seen;

  modport source (
    output valid, mode, mode_12v_pin, proc_alive,
           fan1_high_seen, fan1_low_seen, fan2_high_seen, fan2_low_seen,
    input  ready
  );
  modport sink (
    input  valid, mode, mode_12v_pin, proc_alive,
           fan1_high_seen, fan1_low_seen, fan2_high_seen, fan2_low_seen,
    output ready
  );
endinterface

// result word channel
interface bpss_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] led_bits;
  logic       relay_one;
  logic       relay_two;
  logic [7:0] fan_duty;
  logic [1:0] power_phase;
  logic       high_voltage_mode;

  modport source (
    output valid, led_bits, relay_one, relay_two, fan_duty, power_phase,
           high_voltage_mode,
    input  ready
  );
  modport sink (
    input  valid, led_bits, relay_one, relay_two, fan_duty, power_phase,
           high_voltage_mode,
    output ready
  );
endinterface

// configuration write channel
interface bpss_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/board_power_sequencer_supervisor.sv =====
// Board power sequencer and supervisor. Each input word is either a 1 ms tick
// (mode 0) or a button press (mode 1) and yields exactly one result word with
// the LED, relay, fan duty and phase drives after that word. Words pass an
// input register and a result register, and one word is taken every cycle
// while results are drained; the single state update between the two
// registers sets that rate. The input register can still take one word while
// a result waits at the output. The configuration port is always ready; the
// user must write it only while no word is in flight, which the block does
// not enforce; board variant 3 behaves as the two-LED board.
`default_nettype none

module board_power_sequencer_supervisor
  import bpss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  bpss_in_if.sink   in_ch,
  bpss_out_if.source out_ch,
  bpss_cfg_if.sink  cfg_ch
);

  `include "board_power_sequencer_supervisor_defines.svh"

  // configuration registers
  logic [1:0]  variant_r;
  logic [7:0]  run_duty_r;
  logic [7:0]  fail_duty_r;
  logic [7:0]  fan_hold_r;
  logic [15:0] switch_delay_r;
  logic [15:0] blink_half_r;

  // input stage
  logic       s1_valid_r;
  logic       s1_press_r;
  logic       s1_pin12_r;
  logic       s1_alive_r;
  logic [FAN_LINES-1:0] s1_seen_r;

  // sequencer state
  bpss_phase_t phase_r, phase_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [15:0] blink_cnt_r, blink_cnt_nxt;
  logic        blink_ph_r, blink_ph_nxt;

  // result stage
  logic       out_valid_r;
  logic [4:0] led_r, led_nxt;
  logic       rly1_r, rly1_nxt;
  logic       rly2_r, rly2_nxt;
  logic [7:0] duty_r, duty_nxt;
  logic [1:0] phase_out_r;
  logic       hv_r;

  logic           out_free;
  logic           s1_go;
  logic           seq;
  logic           tick;
  logic           healthy;
  logic           blink_on;
  logic [15:0]    blink_inc;
  bpss_fan_ctl_t  fan_ctl;
  bpss_fan_stat_t fan_stat;

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign cfg_ch.ready = 1'b1;

  assign seq  = (variant_r == VAR_RELAY_BOARD) ||
                ((variant_r == VAR_FAN_BOARD) && s1_pin12_r);
  assign tick = s1_go && !s1_press_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r      <= RST_BOARD_VARIANT;
      run_duty_r     <= RST_FAN_RUN_DUTY;
      fail_duty_r    <= RST_FAN_FAIL_DUTY;
      fan_hold_r     <= RST_FAN_HOLD;
      switch_delay_r <= RST_SWITCH_DELAY;
      blink_half_r   <= RST_BLINK_HALF;
    end else if (cfg_ch.valid) begin
      case (bpss_cfg_idx_t'(cfg_ch.index))
        CFG_BOARD_VARIANT: variant_r      <= cfg_ch.data[1:0];
        CFG_FAN_RUN_DUTY:  run_duty_r     <= cfg_ch.data[7:0];
        CFG_FAN_FAIL_DUTY: fail_duty_r    <= cfg_ch.data[7:0];
        CFG_FAN_HOLD:      fan_hold_r     <= cfg_ch.data[7:0];
        CFG_SWITCH_DELAY:  switch_delay_r <= cfg_ch.data;
        CFG_BLINK_HALF:    blink_half_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_press_r <= in_ch.mode;
      s1_pin12_r <= in_ch.mode_12v_pin;
      s1_alive_r <= in_ch.proc_alive;
      s1_seen_r  <= {in_ch.fan2_low_seen, in_ch.fan2_high_seen,
                     in_ch.fan1_low_seen, in_ch.fan1_high_seen};
    end
  end

  // fan activity monitor
  assign fan_ctl.tick = tick;
  assign fan_ctl.hold = fan_hold_r;

  bpss_fan_monitor u_fan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fan_ctl),
    .seen  (s1_seen_r),
    .stat  (fan_stat)
  );

  // blink divider
  assign blink_inc = blink_cnt_r + 16'd1;

  always_comb begin
    blink_cnt_nxt = blink_cnt_r;
    blink_ph_nxt  = blink_ph_r;
    if (tick) begin
      if (blink_inc >= blink_half_r) begin
        blink_cnt_nxt = 16'd0;
        blink_ph_nxt  = !blink_ph_r;
      end else begin
        blink_cnt_nxt = blink_inc;
      end
    end
  end

  // sequencer next state
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    if (s1_go && seq) begin
      if (s1_press_r) begin
        case (phase_r)
          PH_DOWN: begin
            phase_nxt = PH_ON;
            timer_nxt = switch_delay_r;
          end
          PH_ON: begin
            phase_nxt = PH_DOWN;
            timer_nxt = 16'd0;
          end
          PH_UP: begin
            phase_nxt = PH_OFF;
            timer_nxt = switch_delay_r;
          end
          default: begin
            phase_nxt = PH_UP;
            timer_nxt = 16'd0;
          end
        endcase
      end else if (phase_r == PH_ON || phase_r == PH_OFF) begin
        if (timer_r <= 16'd1) begin
          phase_nxt = (phase_r == PH_ON) ? PH_UP : PH_DOWN;
          timer_nxt = 16'd0;
        end else begin
          timer_nxt = timer_r - 16'd1;
        end
      end
    end
  end

  // result drives from the updated state
  assign healthy  = (variant_r != VAR_FAN_BOARD) || fan_stat.all_seen_nxt;
  assign blink_on = !blink_ph_nxt;

  always_comb begin
    led_nxt  = 5'd0;
    rly1_nxt = 1'b0;
    rly2_nxt = 1'b0;
    duty_nxt = 8'd0;
    if (seq) begin
      led_nxt[4] = (phase_nxt == PH_ON) || (phase_nxt == PH_UP);
      led_nxt[2] = (phase_nxt != PH_DOWN);
      rly1_nxt   = (phase_nxt != PH_DOWN);
      led_nxt[3] = (phase_nxt == PH_UP);
      rly2_nxt   = (phase_nxt == PH_UP);
      if (phase_nxt == PH_DOWN) begin
        led_nxt[0] = 1'b1;
      end else begin
        led_nxt[0] = healthy ? 1'b1 : blink_on;
        duty_nxt   = healthy ? run_duty_r : fail_duty_r;
        led_nxt[1] = s1_alive_r ? 1'b1 : blink_on;
      end
    end else begin
      led_nxt[1] = healthy ? 1'b1 : blink_on;
      duty_nxt   = healthy ? run_duty_r : fail_duty_r;
      led_nxt[2] = s1_alive_r ? 1'b1 : blink_on;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DOWN;
      timer_r     <= 16'd0;
      blink_cnt_r <= 16'd0;
      blink_ph_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      blink_ph_r  <= blink_ph_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      led_r       <= led_nxt;
      rly1_r      <= rly1_nxt;
      rly2_r      <= rly2_nxt;
      duty_r      <= duty_nxt;
      phase_out_r <= phase_nxt;
      hv_r        <= seq;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.led_bits          = led_r;
  assign out_ch.relay_one         = rly1_r;
  assign out_ch.relay_two         = rly2_r;
  assign out_ch.fan_duty          = duty_r;
  assign out_ch.power_phase       = phase_out_r;
  assign out_ch.high_voltage_mode = hv_r;

  // checks
  `BPSS_ASSERT_NOW(a_stall_blocks_input, clk, rst_n,
    s1_valid_r && out_valid_r && !out_ch.ready, !in_ch.ready,
    "input taken while both stages are full")
  `BPSS_ASSERT_NEXT(a_down_only_to_on, clk, rst_n,
    phase_r == PH_DOWN, phase_r == PH_DOWN || phase_r == PH_ON,
    "power left the down phase other than by switching on")
  `BPSS_ASSERT_NOW(a_simple_no_relays, clk, rst_n,
    out_valid_r && !hv_r, !rly1_r && !rly2_r && !led_r[0] && !led_r[3] && !led_r[4],
    "relay or sequencer led driven in simple mode")
  `BPSS_ASSERT_NOW(a_relay_order, clk, rst_n,
    out_valid_r && rly2_r, rly1_r && hv_r,
    "second relay energised without the first")

endmodule

`default_nettype wire

// ===== hw/rtl/bpss_fan_monitor.sv =====
// fan tachometer activity monitor with per-level hold counters
`default_nettype none

module bpss_fan_monitor
  import bpss_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bpss_fan_ctl_t        ctl,
  input  wire logic [FAN_LINES-1:0] seen,
  output bpss_fan_stat_t            stat
);

  logic [7:0] cnt_r   [FAN_LINES];
  logic [7:0] cnt_nxt [FAN_LINES];
  logic [FAN_LINES-1:0] live;

  // reload on a seen level, otherwise count down to zero on each tick
  always_comb begin
    for (int i = 0; i < FAN_LINES; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (ctl.tick) begin
        if (seen[i]) begin
          cnt_nxt[i] = ctl.hold;
        end else if (cnt_r[i] != 8'd0) begin
          cnt_nxt[i] = cnt_r[i] - 8'd1;
        end
      end
      live[i] = (cnt_nxt[i] != 8'd0);
    end
  end

  // health is judged on the updated counts
  assign stat.all_seen_nxt = &live;

  // hold counters
  always_ff @(posedge clk) begin
    for (int i = 0; i < FAN_LINES; i++) begin
      if (!rst_n) begin
        cnt_r[i] <= 8'd0;
      end else begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire
